// File: design/ipv4f_pkg.sv
// Package for the IPv4 longest-prefix-match forwarding block.
// Holds the result codes, the sequencer states, the route entry layout and the mask helper.
// No dependencies.
`default_nettype none

package ipv4f_pkg;

    typedef enum logic [2:0] {
        ACT_LOCAL    = 3'd0,
        ACT_FORWARD  = 3'd1,
        ACT_TTL_DROP = 3'd2,
        ACT_NO_ROUTE = 3'd3,
        ACT_STORED   = 3'd4,
        ACT_FULL     = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_FOLD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [5:0]  len;
        logic [31:0] hop;
    } entry_t;

    localparam logic [31:0] BCAST_ADDR     = 32'hFFFF_FFFF;
    localparam logic [5:0]  MAX_PREFIX_LEN = 6'd32;
    localparam logic [3:0]  CSUM_LAST_WORD = 4'd9;
    localparam logic        REG_LOCAL_ADDR = 1'b0;

    // Leading-ones mask for a prefix length; zero length gives an empty mask.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0)
        begin
            mask = 32'h0;
        end
        else if (len >= MAX_PREFIX_LEN)
        begin
            mask = 32'hFFFF_FFFF;
        end
        else
        begin
            mask = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// File: design/ipv4_forward_lpm.sv
// Top level of the IPv4 longest-prefix-match forwarding block.
// Depends on ipv4f_pkg and ipv4f_ram (route table storage).
//
//   channel   signals                                       direction
//   input     in_valid / in_stall + mode .. route_next_hop  into block
//   output    out_valid / out_stall + action .. checksum_out out of block
//   config    APB: psel penable pwrite paddr pwdata prdata   register access
//
// A route add or a local delivery passes from the result registers into the output register.
// A forward scans the table one entry per cycle through the RAM read port; if a route matches
// and the TTL is nonzero, it then sums the ten header words one per cycle and folds carries.
// One transaction is in work at a time; in_stall is high until its result reaches the
// output register, which holds it while out_stall is high. Reset empties the table by
// clearing the entry count.
`default_nettype none

module ipv4_forward_lpm #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [63:0] header_front,
    input  wire logic [7:0]  ttl_in,
    input  wire logic [7:0]  protocol_in,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] dest_address,
    input  wire logic [31:0] route_prefix,
    input  wire logic [5:0]  prefix_length,
    input  wire logic [31:0] route_next_hop,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic [31:0]      next_hop_out,
    output logic [7:0]       ttl_out,
    output logic [15:0]      checksum_out,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import ipv4f_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] TABLE_CAP = CW'(TABLE_ENTRIES);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [5:0]    best_len_reg, best_len_next;
    logic [31:0]   best_hop_reg, best_hop_next;
    logic [3:0]    word_idx_reg, word_idx_next;
    logic [19:0]   sum_reg, sum_next;
    logic [31:0]   local_addr_reg;

    logic [63:0]   front_reg;
    logic [7:0]    ttl_reg;
    logic [7:0]    proto_reg;
    logic [31:0]   src_reg;
    logic [31:0]   dst_reg;
    logic          hdr_load;

    action_t       res_action_reg, res_action_next;
    logic [31:0]   res_hop_reg, res_hop_next;
    logic [7:0]    res_ttl_reg, res_ttl_next;
    logic [15:0]   res_csum_reg, res_csum_next;

    logic          out_valid_reg, out_valid_next;
    action_t       out_action_reg;
    logic [31:0]   out_hop_reg;
    logic [7:0]    out_ttl_reg;
    logic [15:0]   out_csum_reg;
    logic          out_load;

    logic          in_accept;
    logic          ram_we;
    logic          ram_re;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    logic [7:0]    ttl_dec;
    logic [15:0]   csum_word;
    logic          entry_hit;
    logic          cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_LOCAL_ADDR) ? local_addr_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= 32'h0;
        end
        else if (cfg_write && paddr[2] == REG_LOCAL_ADDR)
        begin
            local_addr_reg <= pwdata;
        end
    end

    // ---------------- route table ----------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign ram_we    = in_accept && mode && (count_reg < TABLE_CAP);

    always_comb
    begin
        ram_wdata.key = route_prefix;
        ram_wdata.len = (prefix_length > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : prefix_length;
        ram_wdata.hop = route_next_hop;
    end

    ipv4f_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign entry_hit = (ram_rdata.len > best_len_reg) &&
                       (((dst_reg ^ ram_rdata.key) & prefix_mask(ram_rdata.len)) == 32'h0);

    // ---------------- checksum words ----------------
    assign ttl_dec = ttl_reg - 8'd1;

    always_comb
    begin
        case (word_idx_reg)
            4'd0:    csum_word = front_reg[63:48];
            4'd1:    csum_word = front_reg[47:32];
            4'd2:    csum_word = front_reg[31:16];
            4'd3:    csum_word = front_reg[15:0];
            4'd4:    csum_word = {ttl_dec, proto_reg};
            4'd5:    csum_word = src_reg[31:16];
            4'd6:    csum_word = src_reg[15:0];
            4'd7:    csum_word = dst_reg[31:16];
            4'd8:    csum_word = dst_reg[15:0];
            default: csum_word = 16'h0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            best_len_reg <= 6'd0;
            word_idx_reg <= 4'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            rd_vld_reg   <= rd_vld_next;
            best_len_reg <= best_len_next;
            word_idx_reg <= word_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_hop_reg   <= best_hop_next;
        sum_reg        <= sum_next;
        res_action_reg <= res_action_next;
        res_hop_reg    <= res_hop_next;
        res_ttl_reg    <= res_ttl_next;
        res_csum_reg   <= res_csum_next;
        if (hdr_load)
        begin
            front_reg <= header_front;
            ttl_reg   <= ttl_in;
            proto_reg <= protocol_in;
            src_reg   <= source_address;
            dst_reg   <= dest_address;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        best_len_next   = best_len_reg;
        best_hop_next   = best_hop_reg;
        word_idx_next   = word_idx_reg;
        sum_next        = sum_reg;
        res_action_next = res_action_reg;
        res_hop_next    = res_hop_reg;
        res_ttl_next    = res_ttl_reg;
        res_csum_next   = res_csum_reg;
        hdr_load        = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_hop_next  = 32'h0;
                    res_ttl_next  = 8'h0;
                    res_csum_next = 16'h0;
                    if (mode)
                    begin
                        if (count_reg < TABLE_CAP)
                        begin
                            count_next      = count_reg + CW'(1);
                            res_action_next = ACT_STORED;
                        end
                        else
                        begin
                            res_action_next = ACT_FULL;
                        end
                        state_next = ST_DONE;
                    end
                    else if (dest_address == BCAST_ADDR || dest_address == local_addr_reg)
                    begin
                        res_action_next = ACT_LOCAL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        hdr_load      = 1'b1;
                        rd_idx_next   = '0;
                        best_len_next = 6'd0;
                        best_hop_next = 32'h0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare the entry that the RAM returns in the next cycle
                if (rd_idx_reg != count_reg)
                begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (rd_vld_reg && entry_hit)
                begin
                    best_len_next = ram_rdata.len;
                    best_hop_next = ram_rdata.hop;
                end
                if (rd_idx_reg == count_reg && !rd_vld_reg)
                begin
                    if (best_len_reg == 6'd0)
                    begin
                        res_action_next = ACT_NO_ROUTE;
                        state_next      = ST_DONE;
                    end
                    else if (ttl_reg == 8'd0)
                    begin
                        res_action_next = ACT_TTL_DROP;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        word_idx_next = 4'd0;
                        sum_next      = 20'h0;
                        state_next    = ST_SUM;
                    end
                end
            end

            ST_SUM:
            begin
                sum_next      = sum_reg + {4'h0, csum_word};
                word_idx_next = word_idx_reg + 4'd1;
                if (word_idx_reg == CSUM_LAST_WORD)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                // fold carries back until the sum fits 16 bits
                if (sum_reg[19:16] != 4'h0)
                begin
                    sum_next = {4'h0, sum_reg[15:0]} + {16'h0, sum_reg[19:16]};
                end
                else
                begin
                    res_action_next = ACT_FORWARD;
                    res_hop_next    = best_hop_reg;
                    res_ttl_next    = ttl_dec;
                    res_csum_next   = ~sum_reg[15:0];
                    state_next      = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    assign out_load       = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_action_reg <= res_action_reg;
            out_hop_reg    <= res_hop_reg;
            out_ttl_reg    <= res_ttl_reg;
            out_csum_reg   <= res_csum_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = out_action_reg;
    assign next_hop_out = out_hop_reg;
    assign ttl_out      = out_ttl_reg;
    assign checksum_out = out_csum_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TABLE_CAP)
        else $error("route count exceeds table size");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < TABLE_CAP && state_reg == ST_IDLE))
        else $error("table write without room or outside idle");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= count_reg)
        else $error("scan index ran past stored routes");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("finished result not loaded into output register");

    a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_action_reg == ACT_FORWARD) |-> (out_ttl_reg != 8'hFF))
        else $error("forwarded packet with wrapped ttl");

endmodule

`default_nettype wire

// File: design/ipv4f_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the route table; no package dependency.
`default_nettype none

module ipv4f_ram #(
    parameter int WIDTH  = 70,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
